FILE: hw/rtl/ssdf_pkg.sv
// Shared types, constants and kernel tables for the supersample downsample filter.
// Used by ssdf_accum and supersample_downsample_filter; depends on nothing else.
`default_nettype none

package ssdf_pkg;

    localparam int MAX_OUT_WIDTH  = 1024;
    localparam int MAX_OUT_HEIGHT = 1024;
    localparam int COL_W          = $clog2(MAX_OUT_WIDTH);
    localparam int ROW_W          = $clog2(MAX_OUT_HEIGHT);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam int PIX_W       = 8;
    localparam int NUM_CHAN    = 3;
    localparam int WEIGHT_W    = 5;
    localparam int SUM_W       = 16;
    localparam int POS_W       = 15;
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_W      = POS_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam int WORD_W      = SUM_W * NUM_CHAN;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE      = 3'd0,
        CFG_KERNEL_SIZE = 3'd1,
        CFG_FILTER_TYPE = 3'd2,
        CFG_OUT_WIDTH   = 3'd3,
        CFG_OUT_HEIGHT  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] in_red;
        logic [PIX_W-1:0] in_green;
        logic [PIX_W-1:0] in_blue;
        logic             frame_start;
    } in_beat_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
        logic             frame_last;
    } out_beat_t;

    // Request into the column accumulator; channel 0 is red.
    typedef struct packed {
        logic                                bypass;
        logic                                fresh;
        logic                                emit;
        logic                                last;
        logic [2:0]                          norm_sel;
        logic signed [WEIGHT_W-1:0]          weight;
        logic [COL_W-1:0]                    col;
        logic [NUM_CHAN-1:0][PIX_W-1:0]      pix;
    } acc_req_t;

    // Finished block sums (clamped at zero) or a bypassed pixel.
    typedef struct packed {
        logic                                bypass;
        logic                                last;
        logic [2:0]                          norm_sel;
        logic [NUM_CHAN-1:0][POS_W-1:0]      chan;
    } acc_rsp_t;

    localparam int TAPS [0:1][0:3][0:4][0:4] = '{
        '{
            '{'{1,1,1,0,0}, '{1,1,1,0,0}, '{1,1,1,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}},
            '{'{1,2,1,0,0}, '{2,4,2,0,0}, '{1,2,1,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}},
            '{'{1,2,1,0,0}, '{2,5,2,0,0}, '{1,2,1,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}},
            '{'{2,3,2,0,0}, '{3,4,3,0,0}, '{2,3,2,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}}
        },
        '{
            '{'{1,1,1,1,1}, '{1,1,1,1,1}, '{1,1,1,1,1}, '{1,1,1,1,1}, '{1,1,1,1,1}},
            '{'{1,2,3,2,1}, '{2,4,6,4,2}, '{3,6,9,6,3}, '{2,4,6,4,2}, '{1,2,3,2,1}},
            '{'{1,1,1,1,1}, '{1,2,4,2,1}, '{1,4,10,4,1}, '{1,2,4,2,1}, '{1,1,1,1,1}},
            '{'{-2,-1,0,-1,-2}, '{-1,4,6,4,-1}, '{0,6,9,6,0}, '{-1,4,6,4,-1},
              '{-2,-1,0,-1,-2}}
        }
    };

    function automatic logic signed [WEIGHT_W-1:0] tap_weight(
        input logic       ks,
        input logic [1:0] ft,
        input logic [2:0] r,
        input logic [2:0] s
    );
        return WEIGHT_W'(TAPS[ks][ft][r][s]);
    endfunction

    // ceil(2^24 / norm); exact floor division for any sum below 2^15.
    function automatic logic [RECIP_W-1:0] recip(input logic [2:0] sel);
        logic [RECIP_W-1:0] m;
        case (sel)
            3'd0:    m = 21'd1864136;
            3'd1:    m = 21'd1048576;
            3'd2:    m = 21'd986896;
            3'd3:    m = 21'd699051;
            3'd4:    m = 21'd671089;
            3'd5:    m = 21'd207127;
            3'd6:    m = 21'd335545;
            3'd7:    m = 21'd508401;
            default: m = 21'd1864136;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ssdf_accum.sv
// Column accumulator: the column-sum RAM with its read-modify-write stage and output stage.
// Depends on ssdf_pkg.
`default_nettype none

module ssdf_accum (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ssdf_pkg::acc_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output ssdf_pkg::acc_rsp_t rsp
);
    import ssdf_pkg::*;

    logic [WORD_W-1:0] mem [MAX_OUT_WIDTH];

    logic              s1_valid_reg;
    acc_req_t          s1_req_reg;
    logic [WORD_W-1:0] rdata_reg;
    logic              fwd_hit_reg;
    logic [WORD_W-1:0] fwd_sum_reg;
    logic              s2_valid_reg;
    acc_rsp_t          s2_rsp_reg;

    logic              s1_ready;
    logic              s2_ready;
    logic              accept;
    logic              s1_fire;
    logic              wr_en;
    logic              keep;
    logic              fwd_hit_next;
    logic [WORD_W-1:0] base_word;
    logic [WORD_W-1:0] sum_word_next;
    acc_rsp_t          s2_rsp_next;

    logic signed [SUM_W-1:0] base_ch [NUM_CHAN];
    logic signed [SUM_W-1:0] new_ch  [NUM_CHAN];
    logic signed [SUM_W-1:0] wt_ext;
    logic signed [SUM_W-1:0] px_ext  [NUM_CHAN];

    assign s2_ready  = !s2_valid_reg || rsp_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req_ready = s1_ready;
    assign accept    = req_valid && s1_ready;
    assign s1_fire   = s1_valid_reg && s2_ready;
    assign wr_en     = s1_fire && !s1_req_reg.bypass;
    assign keep      = s1_req_reg.bypass || s1_req_reg.emit;

    // A write-back at the same edge as the next read of that column is caught here.
    assign fwd_hit_next = wr_en && (s1_req_reg.col == req.col);

    always_comb
    begin
        if (s1_req_reg.fresh) begin
            base_word = '0;
        end else if (fwd_hit_reg) begin
            base_word = fwd_sum_reg;
        end else begin
            base_word = rdata_reg;
        end
        wt_ext = SUM_W'(s1_req_reg.weight);
        s2_rsp_next.bypass   = s1_req_reg.bypass;
        s2_rsp_next.last     = s1_req_reg.last;
        s2_rsp_next.norm_sel = s1_req_reg.norm_sel;
        for (int c = 0; c < NUM_CHAN; c++) begin
            base_ch[c] = base_word[(NUM_CHAN-1-c)*SUM_W +: SUM_W];
            px_ext[c]  = signed'(SUM_W'(s1_req_reg.pix[c]));
            new_ch[c]  = base_ch[c] + wt_ext * px_ext[c];
            sum_word_next[(NUM_CHAN-1-c)*SUM_W +: SUM_W] = new_ch[c];
            if (s1_req_reg.bypass) begin
                s2_rsp_next.chan[c] = POS_W'(s1_req_reg.pix[c]);
            end else if (new_ch[c][SUM_W-1]) begin
                s2_rsp_next.chan[c] = '0;
            end else begin
                s2_rsp_next.chan[c] = new_ch[c][POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[s1_req_reg.col] <= sum_word_next;
        end
        if (accept) begin
            rdata_reg <= mem[req.col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_req_reg  <= req;
            fwd_sum_reg <= sum_word_next;
        end
        if (s1_fire && keep) begin
            s2_rsp_reg <= s2_rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= req_valid;
            end
            if (accept) begin
                fwd_hit_reg <= fwd_hit_next;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_fire && keep;
            end
        end
    end

    assign rsp_valid = s2_valid_reg;
    assign rsp       = s2_rsp_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/supersample_downsample_filter.sv
// Top level of the supersample downsample filter: configuration, raster counters,
// normalizing divide and output register. Depends on ssdf_pkg and ssdf_accum.
`default_nettype none

// The filter takes one supersampled pixel per clock while in_stall is low and, per k-by-k
// block, presents one output beat; bypass beats take the same path. Column partial sums live
// in a 1024 x 48 RAM that is read when a beat is taken and written back as it leaves the
// read-modify-write stage, with a forwarding register covering back-to-back samples of the
// same column, so the sustained rate is one beat per cycle while out_stall is low. The RAM is
// not cleared after reset: each band starts its columns from zero on the first sample.
module supersample_downsample_filter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  ssdf_pkg::in_beat_t                  in_beat,
    output logic                                out_valid,
    input  logic                                out_stall,
    output ssdf_pkg::out_beat_t                 out_beat,
    input  logic                                cfg_we,
    input  logic [ssdf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssdf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ssdf_pkg::*;

    localparam int CMP_W = COL_W + CFG_DATA_W;

    logic                  enable_reg;
    logic                  kernel_size_reg;
    logic [1:0]            filter_type_reg;
    logic [CFG_DATA_W-1:0] out_width_reg;
    logic [CFG_DATA_W-1:0] out_height_reg;

    logic [2:0]       sub_col_reg;
    logic [COL_W-1:0] blk_col_reg;
    logic [2:0]       sub_row_reg;
    logic [ROW_W-1:0] out_row_reg;

    logic [2:0]       sub_col_next;
    logic [COL_W-1:0] blk_col_next;
    logic [2:0]       sub_row_next;
    logic [ROW_W-1:0] out_row_next;

    logic [2:0]       sc;
    logic [COL_W-1:0] bc;
    logic [2:0]       sr;
    logic [ROW_W-1:0] orow;
    logic [2:0]       k_m1;
    logic [COL_W-1:0] w_m1;
    logic [ROW_W-1:0] h_m1;
    logic [CMP_W-1:0] ow_ext;
    logic [CMP_W-1:0] oh_ext;
    logic [2:0]       tap_r;
    logic [2:0]       tap_s;
    logic             last_col;
    logic             last_blk;
    logic             last_row;
    logic             last_out;
    logic             accept;

    acc_req_t req;
    logic     acc_ready;
    logic     rsp_valid;
    logic     rsp_ready;
    acc_rsp_t rsp;

    logic                  s3_valid_reg;
    logic                  s3_last_reg;
    logic [PROD_W-1:0]     prod_reg  [NUM_CHAN];
    logic [PROD_W-1:0]     prod_next [NUM_CHAN];
    logic [RECIP_W-1:0]    recip_val;
    logic                  s3_ready;
    logic                  out_ready;

    logic                  out_valid_reg;
    out_beat_t             out_beat_reg;
    out_beat_t             out_beat_next;
    logic [QUOT_W-1:0]     quot [NUM_CHAN];
    logic [PIX_W-1:0]      sat  [NUM_CHAN];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            enable_reg      <= 1'b1;
            kernel_size_reg <= 1'b0;
            filter_type_reg <= 2'd0;
            out_width_reg   <= CFG_DATA_W'(640);
            out_height_reg  <= CFG_DATA_W'(480);
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_ENABLE:      enable_reg      <= cfg_data[0];
                CFG_KERNEL_SIZE: kernel_size_reg <= cfg_data[0];
                CFG_FILTER_TYPE: filter_type_reg <= cfg_data[1:0];
                CFG_OUT_WIDTH:   out_width_reg   <= cfg_data;
                CFG_OUT_HEIGHT:  out_height_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Raster position and request build.
    always_comb
    begin
        k_m1   = kernel_size_reg ? 3'd4 : 3'd2;
        ow_ext = CMP_W'(out_width_reg);
        oh_ext = CMP_W'(out_height_reg);
        if (ow_ext == '0) begin
            w_m1 = '0;
        end else if (ow_ext > CMP_W'(MAX_OUT_WIDTH)) begin
            w_m1 = COL_W'(MAX_OUT_WIDTH - 1);
        end else begin
            w_m1 = COL_W'(ow_ext - CMP_W'(1));
        end
        if (oh_ext == '0) begin
            h_m1 = '0;
        end else if (oh_ext > CMP_W'(MAX_OUT_HEIGHT)) begin
            h_m1 = ROW_W'(MAX_OUT_HEIGHT - 1);
        end else begin
            h_m1 = ROW_W'(oh_ext - CMP_W'(1));
        end

        if (in_beat.frame_start) begin
            sc   = '0;
            bc   = '0;
            sr   = '0;
            orow = '0;
        end else begin
            sc   = sub_col_reg;
            bc   = blk_col_reg;
            sr   = sub_row_reg;
            orow = out_row_reg;
        end

        last_col = sc >= k_m1;
        last_blk = bc >= w_m1;
        last_row = sr >= k_m1;
        last_out = orow >= h_m1;

        sub_col_next = sc;
        blk_col_next = bc;
        sub_row_next = sr;
        out_row_next = orow;
        if (!last_col) begin
            sub_col_next = sc + 3'd1;
        end else begin
            sub_col_next = '0;
            if (!last_blk) begin
                blk_col_next = bc + COL_W'(1);
            end else begin
                blk_col_next = '0;
                if (!last_row) begin
                    sub_row_next = sr + 3'd1;
                end else begin
                    sub_row_next = '0;
                    out_row_next = last_out ? '0 : orow + ROW_W'(1);
                end
            end
        end

        tap_r = (sr > 3'd4) ? 3'd4 : sr;
        tap_s = (sc > 3'd4) ? 3'd4 : sc;

        req.bypass   = !enable_reg;
        req.fresh    = (sr == '0) && (sc == '0);
        req.emit     = last_col && last_row;
        req.last     = enable_reg ? (last_blk && last_out)
                                  : (last_col && last_blk && last_row && last_out);
        req.norm_sel = {kernel_size_reg, filter_type_reg};
        req.weight   = tap_weight(kernel_size_reg, filter_type_reg, tap_r, tap_s);
        req.col      = bc;
        req.pix[0]   = in_beat.in_red;
        req.pix[1]   = in_beat.in_green;
        req.pix[2]   = in_beat.in_blue;
    end

    assign accept   = in_valid && acc_ready;
    assign in_stall = !acc_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sub_col_reg <= '0;
            blk_col_reg <= '0;
            sub_row_reg <= '0;
            out_row_reg <= '0;
        end else if (accept) begin
            sub_col_reg <= sub_col_next;
            blk_col_reg <= blk_col_next;
            sub_row_reg <= sub_row_next;
            out_row_reg <= out_row_next;
        end
    end

    ssdf_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_ready (acc_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Division by the kernel normalizer as a reciprocal multiply; bypassed pixels pass unscaled.
    assign out_ready = !out_valid_reg || !out_stall;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign rsp_ready = s3_ready;
    assign recip_val = recip(rsp.norm_sel);

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            if (rsp.bypass) begin
                prod_next[c] = PROD_W'(rsp.chan[c]) << RECIP_SHIFT;
            end else begin
                prod_next[c] = PROD_W'(rsp.chan[c]) * PROD_W'(recip_val);
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            quot[c] = prod_reg[c][RECIP_SHIFT +: QUOT_W];
            sat[c]  = (quot[c] > QUOT_W'(255)) ? 8'hFF : quot[c][PIX_W-1:0];
        end
        out_beat_next.out_red    = sat[0];
        out_beat_next.out_green  = sat[1];
        out_beat_next.out_blue   = sat[2];
        out_beat_next.frame_last = s3_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rsp_valid && s3_ready) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
                prod_reg[c] <= prod_next[c];
            end
            s3_last_reg <= rsp.last;
        end
        if (s3_valid_reg && out_ready) begin
            out_beat_reg <= out_beat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s3_ready) begin
                s3_valid_reg <= rsp_valid;
            end
            if (out_ready) begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for supersample_downsample_filter: streams supersampled pixel
// beats, predicts each filtered or bypassed output pixel and compares it field by field.
// Depends on ssdf_pkg and the filter RTL; needs no other files.

module testbench;
    import ssdf_pkg::*;

    localparam int CYCLE_LIMIT    = 500000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int RANDOM_PIXELS  = 1500;

    localparam bit KS_3X3 = 1'b0;
    localparam bit KS_5X5 = 1'b1;

    localparam int FT_BOX      = 0;
    localparam int FT_TRIANGLE = 1;
    localparam int FT_GAUSSIAN = 2;
    localparam int FT_SINC     = 3;

    localparam int PAT_NOISE = 0;
    localparam int PAT_FULL  = 1;
    localparam int PAT_ZERO  = 2;
    localparam int PAT_CORE  = 3;
    localparam int PAT_RING  = 4;

    localparam int IDLE_FEED_HEAVY = 0;
    localparam int IDLE_SINK_HEAVY = 1;
    localparam int IDLE_NONE       = 2;

    localparam int KERNEL_WEIGHT [0:1][0:3][0:4][0:4] = '{
        '{
            '{'{1,1,1,0,0}, '{1,1,1,0,0}, '{1,1,1,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}},
            '{'{1,2,1,0,0}, '{2,4,2,0,0}, '{1,2,1,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}},
            '{'{1,2,1,0,0}, '{2,5,2,0,0}, '{1,2,1,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}},
            '{'{2,3,2,0,0}, '{3,4,3,0,0}, '{2,3,2,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}}
        },
        '{
            '{'{1,1,1,1,1}, '{1,1,1,1,1}, '{1,1,1,1,1}, '{1,1,1,1,1}, '{1,1,1,1,1}},
            '{'{1,2,3,2,1}, '{2,4,6,4,2}, '{3,6,9,6,3}, '{2,4,6,4,2}, '{1,2,3,2,1}},
            '{'{1,1,1,1,1}, '{1,2,4,2,1}, '{1,4,10,4,1}, '{1,2,4,2,1}, '{1,1,1,1,1}},
            '{'{-2,-1,0,-1,-2}, '{-1,4,6,4,-1}, '{0,6,9,6,0}, '{-1,4,6,4,-1},
              '{-2,-1,0,-1,-2}}
        }
    };

    localparam int KERNEL_NORM [0:1][0:3] = '{'{9, 16, 17, 24}, '{25, 81, 50, 33}};

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_beat_t              in_beat   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_beat_t             out_beat;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    in_beat_t  supersamples[$];
    out_beat_t expected_pixels[$];
    out_beat_t head_pixel;

    logic        beat_taken;
    logic        mode_enable;
    logic        mode_ksize;
    logic [1:0]  mode_ftype;
    logic [10:0] frame_width;
    logic [10:0] frame_height;
    int          column_acc [0:MAX_OUT_WIDTH-1][0:2];
    int          sub_col;
    int          block_col;
    int          sub_row;
    int          out_row;

    int feed_gap_pct   = 0;
    int sink_stall_pct = 0;
    int queued_pixels  = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    supersample_downsample_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic downsample_pixel(input in_beat_t px);
        int k, w, h, r, s, wt, nm, q, c;
        int chan [0:2];
        bit lc, lb, lr, lo;
        out_beat_t res;
        chan[0] = px.in_red;
        chan[1] = px.in_green;
        chan[2] = px.in_blue;
        k = mode_ksize ? 5 : 3;
        w = (frame_width == 0) ? 1 : ((frame_width > MAX_OUT_WIDTH) ? MAX_OUT_WIDTH
                                                                    : frame_width);
        h = (frame_height == 0) ? 1 : ((frame_height > MAX_OUT_HEIGHT) ? MAX_OUT_HEIGHT
                                                                       : frame_height);
        if (px.frame_start)
        begin
            sub_col = 0;
            block_col = 0;
            sub_row = 0;
            out_row = 0;
        end
        lc = sub_col >= k - 1;
        lb = block_col >= w - 1;
        lr = sub_row >= k - 1;
        lo = out_row >= h - 1;
        if (!mode_enable)
        begin
            res.out_red = px.in_red;
            res.out_green = px.in_green;
            res.out_blue = px.in_blue;
            res.frame_last = lc && lb && lr && lo;
            expected_pixels.push_back(res);
        end
        else
        begin
            r = (sub_row < 5) ? sub_row : 4;
            s = (sub_col < 5) ? sub_col : 4;
            wt = KERNEL_WEIGHT[mode_ksize][mode_ftype][r][s];
            for (c = 0; c < 3; c++)
            begin
                column_acc[block_col][c] = ((sub_row == 0 && sub_col == 0)
                                            ? 0 : column_acc[block_col][c]) + wt * chan[c];
            end
            if (lc && lr)
            begin
                nm = KERNEL_NORM[mode_ksize][mode_ftype];
                for (c = 0; c < 3; c++)
                begin
                    q = (column_acc[block_col][c] < 0) ? 0 : column_acc[block_col][c] / nm;
                    chan[c] = (q > 255) ? 255 : q;
                end
                res.out_red = 8'(chan[0]);
                res.out_green = 8'(chan[1]);
                res.out_blue = 8'(chan[2]);
                res.frame_last = lb && lo;
                expected_pixels.push_back(res);
            end
        end
        if (!lc)
            sub_col++;
        else
        begin
            sub_col = 0;
            if (!lb)
                block_col++;
            else
            begin
                block_col = 0;
                if (!lr)
                    sub_row++;
                else
                begin
                    sub_row = 0;
                    out_row = lo ? 0 : out_row + 1;
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_taken <= 1'b0;
            mode_enable = 1'b1;
            mode_ksize = KS_3X3;
            mode_ftype = 2'(FT_BOX);
            frame_width = 11'd640;
            frame_height = 11'd480;
            sub_col = 0;
            block_col = 0;
            sub_row = 0;
            out_row = 0;
        end
        else
        begin
            beat_taken <= in_valid && !in_stall;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENABLE:      mode_enable = cfg_data[0];
                    CFG_KERNEL_SIZE: mode_ksize = cfg_data[0];
                    CFG_FILTER_TYPE: mode_ftype = cfg_data[1:0];
                    CFG_OUT_WIDTH:   frame_width = cfg_data;
                    CFG_OUT_HEIGHT:  frame_height = cfg_data;
                    default:         ;
                endcase
            end
            if (in_valid && !in_stall)
                downsample_pixel(in_beat);
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("output beat with no pixel expected: %p", out_beat);
                    mismatches++;
                end
                else
                begin
                    head_pixel = expected_pixels.pop_front();
                    check_field("out_red", head_pixel.out_red, out_beat.out_red);
                    check_field("out_green", head_pixel.out_green, out_beat.out_green);
                    check_field("out_blue", head_pixel.out_blue, out_beat.out_blue);
                    check_field("frame_last", 8'(head_pixel.frame_last), 8'(out_beat.frame_last));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
            if (!in_valid || beat_taken)
            begin
                if (supersamples.size() != 0 && $urandom_range(0, 99) >= feed_gap_pct)
                begin
                    in_beat <= supersamples.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            IDLE_FEED_HEAVY:
            begin
                feed_gap_pct = 38;
                sink_stall_pct = 56;
            end
            IDLE_SINK_HEAVY:
            begin
                feed_gap_pct = 56;
                sink_stall_pct = 38;
            end
            default:
            begin
                feed_gap_pct = 0;
                sink_stall_pct = 0;
            end
        endcase
    endtask

    task automatic write_reg(input cfg_index_t idx, input int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input int en, input int ks, input int ft, input int wd,
                                 input int ht);
        write_reg(CFG_ENABLE, en);
        write_reg(CFG_KERNEL_SIZE, ks);
        write_reg(CFG_FILTER_TYPE, ft);
        write_reg(CFG_OUT_WIDTH, wd);
        write_reg(CFG_OUT_HEIGHT, ht);
    endtask

    task automatic drain();
        while (supersamples.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [7:0] block_value(input int pat, input int k, input int sy,
                                               input int sx);
        bit core;
        core = (k == 5) ? (sy >= 1 && sy <= 3 && sx >= 1 && sx <= 3) : (sy == 1 && sx == 1);
        case (pat)
            PAT_FULL: return 8'hFF;
            PAT_ZERO: return 8'h00;
            PAT_CORE: return core ? 8'hFF : 8'h00;
            PAT_RING: return core ? 8'h00 : 8'hFF;
            default:  return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Each block and channel gets its own pattern so that the sinc taps reach both clamps.
    task automatic queue_frame(input int k, input int w, input int h, input bit start,
                               input int cut);
        int block_pat [0:MAX_OUT_WIDTH-1][0:2];
        int y, x, c, n;
        in_beat_t px;
        n = 0;
        for (y = 0; y < h * k; y++)
        begin
            if (y % k == 0)
            begin
                for (x = 0; x < w; x++)
                begin
                    for (c = 0; c < 3; c++)
                    begin
                        block_pat[x][c] = $urandom_range(0, 5);
                        if (block_pat[x][c] > PAT_RING)
                            block_pat[x][c] = PAT_NOISE;
                    end
                end
            end
            for (x = 0; x < w * k; x++)
            begin
                if (n == cut)
                    return;
                px.in_red = block_value(block_pat[x / k][0], k, y % k, x % k);
                px.in_green = block_value(block_pat[x / k][1], k, y % k, x % k);
                px.in_blue = block_value(block_pat[x / k][2], k, y % k, x % k);
                px.frame_start = (n == 0 && start) || ($urandom_range(0, 299) == 0);
                supersamples.push_back(px);
                n++;
                queued_pixels++;
            end
        end
    endtask

    initial
    begin
        int en, ks, ft, wd, ht, prev_en, prev_wd, k, weff, hgen, frames, cut, i, base;
        bit fresh_start, drained_once;
        in_beat_t px;
        set_idling(IDLE_FEED_HEAVY);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // One full-scale 3x3 box block, then a bypassed frame with zero sizes.
        apply_setting(1, KS_3X3, FT_BOX, 1, 1);
        for (i = 0; i < 9; i++)
        begin
            px.in_red = 8'hFF;
            px.in_green = 8'hFF;
            px.in_blue = 8'hFF;
            px.frame_start = (i == 0);
            supersamples.push_back(px);
        end
        drain();
        apply_setting(0, KS_3X3, FT_SINC, 0, 0);
        for (i = 0; i < 9; i++)
        begin
            px.in_red = (i == 8) ? 8'hFF : 8'(i * 31);
            px.in_green = ~px.in_red;
            px.in_blue = i[0] ? 8'hFF : 8'h00;
            px.frame_start = (i == 0);
            supersamples.push_back(px);
        end
        drain();

        // A new setting may continue a frame only where no unwritten column sum is read.
        prev_en = 0;
        prev_wd = 0;
        drained_once = 1'b0;
        base = queued_pixels;
        while (queued_pixels - base < RANDOM_PIXELS)
        begin
            if (queued_pixels - base < RANDOM_PIXELS / 3)
                set_idling(IDLE_FEED_HEAVY);
            else if (queued_pixels - base < 2 * RANDOM_PIXELS / 3)
                set_idling(IDLE_SINK_HEAVY);
            else
                set_idling(IDLE_NONE);
            en = ($urandom_range(0, 4) != 0);
            ks = $urandom_range(0, 1);
            ft = $urandom_range(0, 3);
            case ($urandom_range(0, 11))
                0:       wd = 2047;
                1, 2:    wd = prev_wd;
                default: wd = $urandom_range(0, 6);
            endcase
            ht = ($urandom_range(0, 9) == 0) ? 1024 + 1023 * $urandom_range(0, 1)
                                              : $urandom_range(0, 3);
            fresh_start = !(en == 0 || (prev_en == 1 && wd == prev_wd)) ||
                          $urandom_range(0, 1);
            apply_setting(en, ks, ft, wd, ht);
            k = ks ? 5 : 3;
            weff = (wd == 0) ? 1 : ((wd > MAX_OUT_WIDTH) ? MAX_OUT_WIDTH : wd);
            hgen = (ht == 0) ? 1 : ((ht > 3) ? 3 : ht);
            frames = $urandom_range(1, 3);
            for (i = 0; i < frames; i++)
            begin
                cut = -1;
                if (weff > 8)
                    cut = $urandom_range(1, 200);
                else if ($urandom_range(0, 3) == 0)
                    cut = $urandom_range(1, k * k * weff * hgen);
                queue_frame(k, weff, hgen, (i == 0) ? fresh_start : $urandom_range(0, 1), cut);
                if (!drained_once && queued_pixels - base > RANDOM_PIXELS / 2)
                begin
                    drain();
                    drained_once = 1'b1;
                end
            end
            drain();
            prev_en = en;
            prev_wd = wd;
        end

        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/ssdf_pkg.sv
hw/rtl/ssdf_accum.sv
hw/rtl/supersample_downsample_filter.sv
verif/testbench.sv
